@@ rtl/core/sbq_pkg.sv @@
// Shared types and constants for the sorted byte queue.
package sbq_pkg;

  localparam int unsigned CapacityDefault = 1024;
  localparam int unsigned NumBins         = 256;
  localparam int unsigned BinW            = 8;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } op_e;

  typedef struct packed {
    op_e             op;
    logic [BinW-1:0] value;
  } item_t;

endpackage

@@ rtl/core/sbq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module sbq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/sbq_front.sv @@
// Front end: accepts requests, decodes them and queues them for the back end.
module sbq_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          opcode_i,
  input  logic [7:0]    byte_value_i,
  output logic          item_valid_o,
  input  logic          item_ready_i,
  output sbq_pkg::item_t item_o
);
  import sbq_pkg::*;

  item_t      slot_q [2];
  logic       wptr_q, rptr_q;
  logic [1:0] count_q;
  item_t      decoded;
  logic       push, pop;

  always_comb begin
    decoded.op    = op_e'(opcode_i);
    // pops carry no byte
    decoded.value = (decoded.op == OP_INSERT) ? byte_value_i : '0;
  end

  assign in_ready_o   = (count_q != 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = slot_q[rptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = item_valid_o && item_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= decoded;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) wptr_q <= ~wptr_q;
      if (pop)  rptr_q <= ~rptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ rtl/core/sbq_back.sv @@
// Back end: count memory, occupancy map and result register.
module sbq_back #(
  parameter int unsigned Capacity = sbq_pkg::CapacityDefault
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  output logic           item_ready_o,
  input  sbq_pkg::item_t item_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_value_o,
  output logic           is_empty_o,
  output logic           overflowed_o
);
  import sbq_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_POP
  } state_e;

  // lowest set bit, found as lowest nonzero group of 16, then bit in group
  function automatic logic [BinW-1:0] lowest_bin(input logic [NumBins-1:0] bm);
    logic [15:0] grp;
    logic [15:0] sel;
    logic [3:0]  g;
    logic [3:0]  b;
    for (int j = 0; j < 16; j++) begin
      grp[j] = |bm[j*16 +: 16];
    end
    g = 4'd0;
    for (int j = 15; j >= 0; j--) begin
      if (grp[j]) g = 4'(j);
    end
    sel = bm[g*16 +: 16];
    b = 4'd0;
    for (int j = 15; j >= 0; j--) begin
      if (sel[j]) b = 4'(j);
    end
    return {g, b};
  endfunction

  state_e              state_q;
  logic [NumBins-1:0]  occ_q;
  logic [CntW-1:0]     total_q;
  logic                ovf_q;
  logic [BinW-1:0]     bin_q;
  logic                out_valid_q;
  logic [7:0]          out_value_q;
  logic                out_empty_q;
  logic                out_ovf_q;

  logic                out_space, take, full, held;
  logic [BinW-1:0]     low_bin;
  logic                ram_we, ram_re;
  logic [BinW-1:0]     ram_raddr;
  logic [CntW-1:0]     ram_wdata, ram_rdata, cur_cnt;

  assign out_space = !out_valid_q || out_ready_i;
  assign full      = (total_q >= CntW'(Capacity));
  assign held      = (total_q != '0);
  assign low_bin   = lowest_bin(occ_q);

  // an empty pop answers at once and needs room in the result register
  assign item_ready_o = (state_q == S_IDLE) &&
                        (item_i.op == OP_INSERT || held || out_space);
  assign take = item_valid_i && item_ready_o;

  // a bin whose map bit is clear has never been written or was drained
  assign cur_cnt = occ_q[bin_q] ? ram_rdata : '0;

  always_comb begin
    ram_re    = take && ((item_i.op == OP_INSERT) ? !full : held);
    ram_raddr = (item_i.op == OP_INSERT) ? item_i.value : low_bin;
    ram_we    = (state_q == S_INS) || (state_q == S_POP && out_space);
    ram_wdata = (state_q == S_INS) ? cur_cnt + CntW'(1) : ram_rdata - CntW'(1);
  end

  sbq_ram #(
    .Width (CntW),
    .Depth (NumBins)
  ) u_counts (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (bin_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      occ_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      bin_q       <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_empty_q <= 1'b0;
      out_ovf_q   <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (take) begin
            if (item_i.op == OP_INSERT) begin
              if (full) begin
                ovf_q <= 1'b1;
              end else begin
                bin_q   <= item_i.value;
                state_q <= S_INS;
              end
            end else if (!held) begin
              out_valid_q <= 1'b1;
              out_value_q <= '0;
              out_empty_q <= 1'b1;
              out_ovf_q   <= ovf_q;
            end else begin
              bin_q   <= low_bin;
              state_q <= S_POP;
            end
          end
        end
        S_INS: begin
          occ_q[bin_q] <= 1'b1;
          total_q      <= total_q + CntW'(1);
          state_q      <= S_IDLE;
        end
        S_POP: begin
          if (out_space) begin
            if (ram_rdata == CntW'(1)) occ_q[bin_q] <= 1'b0;
            total_q     <= total_q - CntW'(1);
            out_valid_q <= 1'b1;
            out_value_q <= bin_q;
            out_empty_q <= 1'b0;
            out_ovf_q   <= ovf_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign is_empty_o   = out_empty_q;
  assign overflowed_o = out_ovf_q;

endmodule

@@ rtl/core/sorted_byte_queue.sv @@
// Sorted byte queue: front request queue plus count-memory back end.
// A pop request passes the front request queue, the count RAM read and the result
// register in turn; a pop on an empty store skips the count RAM read.
// The back end takes no new request during a count RAM read-modify-write, which a pop
// holds until the result register has room; an empty pop or a dropped insert needs none.
// A 2-entry request queue keeps in_ready_o high while the back end is busy, until it fills.
// Reset clears flags, counters and the occupancy map; the map marks which count
// RAM entries hold data, so there is no clearing pass.
module sorted_byte_queue #(
  parameter int unsigned CAPACITY = sbq_pkg::CapacityDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       opcode_i,
  input  logic [7:0] byte_value_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_value_o,
  output logic       is_empty_o,
  output logic       overflowed_o
);
  import sbq_pkg::*;

  logic  item_valid, item_ready;
  item_t item;

  sbq_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .opcode_i     (opcode_i),
    .byte_value_i (byte_value_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  sbq_back #(
    .Capacity (CAPACITY)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_value_o  (out_value_o),
    .is_empty_o   (is_empty_o),
    .overflowed_o (overflowed_o)
  );

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> out_value_o == 8'd0)
    else $error("empty pop returned nonzero value");

  a_ovf_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && overflowed_o |=> !out_valid_o || overflowed_o)
    else $error("overflow flag cleared");

endmodule

@@ bench/sorted_byte_queue_tb.sv @@
// Self-checking testbench for the sorted byte queue: directed table, random traffic, fill to overflow.
`timescale 1ns / 100ps

module sorted_byte_queue_tb;
  import sbq_pkg::*;

  localparam int unsigned Capacity   = CapacityDefault;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned ShowLimit  = 30;

  typedef struct packed {
    logic [7:0] value;
    logic       empty;
    logic       ovf;
  } pop_res_t;

  typedef struct {
    op_e        op;
    logic [7:0] value;
    bit         pinned;
    pop_res_t   res;
  } stim_row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic       opcode_i;
  logic [7:0] byte_value_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic [7:0] out_value_o;
  logic       is_empty_o;
  logic       overflowed_o;

  // hand-typed result riding along with the request, sampled on acceptance
  logic     pin_valid;
  pop_res_t pin_res;

  // mirror of the byte store
  logic [10:0]        bin_count [NumBins];
  logic [NumBins-1:0] bin_used;
  int unsigned        held_total;
  logic               ovf_sticky;
  pop_res_t           pending_pops[$];

  int          err_count;
  int          reqs_taken;
  int          results_seen;
  int          empty_pops;
  int          dropped_inserts;
  int unsigned peak_held;
  bit          no_gap;
  logic [7:0]  hot_base;
  stim_row_t   dir_rows[$];

  sorted_byte_queue #(
    .CAPACITY(Capacity)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .opcode_i    (opcode_i),
    .byte_value_i(byte_value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_value_o (out_value_o),
    .is_empty_o  (is_empty_o),
    .overflowed_o(overflowed_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(input string what, input int got, input int want);
    err_count++;
    if (err_count <= ShowLimit) begin
      $display("%0t mismatch: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Apply one request to the mirror; returns 1 when it yields a pop result.
  function automatic bit predict_request(input op_e op, input logic [7:0] v,
                                         output pop_res_t r);
    int bin;
    r   = '0;
    bin = 0;
    if (op == OP_INSERT) begin
      if (held_total >= Capacity) begin
        ovf_sticky = 1'b1;
        dropped_inserts++;
      end else begin
        bin_count[v]++;
        bin_used[v] = 1'b1;
        held_total++;
      end
      return 1'b0;
    end
    r.ovf = ovf_sticky;
    if (held_total == 0) begin
      r.empty = 1'b1;
      return 1'b1;
    end
    for (int i = NumBins - 1; i >= 0; i--) begin
      if (bin_used[i]) bin = i;
    end
    bin_count[bin]--;
    if (bin_count[bin] == 0) bin_used[bin] = 1'b0;
    held_total--;
    r.value = 8'(bin);
    return 1'b1;
  endfunction

  always @(posedge clk_i) begin : monitor
    pop_res_t got;
    pop_res_t want;
    pop_res_t pred;
    bit       has_res;
    if (rst_ni) begin
      // results first, so a request taken this edge cannot cover a stray result
      if (out_valid_o && out_ready_i) begin
        got = {out_value_o, is_empty_o, overflowed_o};
        results_seen++;
        if (pending_pops.size() == 0) begin
          report_mismatch("result with no pop pending, out_value", got.value, 0);
        end else begin
          want = pending_pops.pop_front();
          if (got.value !== want.value) report_mismatch("out_value", got.value, want.value);
          if (got.empty !== want.empty) report_mismatch("is_empty", got.empty, want.empty);
          if (got.ovf !== want.ovf) report_mismatch("overflowed", got.ovf, want.ovf);
        end
      end
      if (in_valid_i && in_ready_o) begin
        reqs_taken++;
        has_res = predict_request(op_e'(opcode_i), byte_value_i, pred);
        if (has_res) begin
          pending_pops.push_back(pin_valid ? pin_res : pred);
          if (pred.empty) empty_pops++;
        end
        if (held_total > peak_held) peak_held = held_total;
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gap) return 0;
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // corners, a narrow hot range for repeats, and uniform bytes
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      case ($urandom_range(0, 5))
        0: return 8'h00;
        1: return 8'h01;
        2: return 8'h7F;
        3: return 8'h80;
        4: return 8'hFE;
        default: return 8'hFF;
      endcase
    end
    if (r < 55) return hot_base + 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic stim_row_t mk_row(input op_e op, input logic [7:0] v, input bit pinned,
                                       input logic [7:0] pv, input logic pe);
    stim_row_t row;
    row.op     = op;
    row.value  = v;
    row.pinned = pinned;
    row.res    = {pv, pe, 1'b0};
    return row;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input op_e op, input logic [7:0] v, input bit pinned,
                              input pop_res_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    opcode_i     <= op;
    byte_value_i <= v;
    pin_valid    <= pinned;
    pin_res      <= res;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic send_random(input int pop_pct);
    op_e op;
    op = ($urandom_range(0, 99) < pop_pct) ? OP_POP : OP_INSERT;
    send_request(op, pick_byte(), 1'b0, '0);
  endtask

  task automatic idle_cycles(input int n);
    in_valid_i <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // receiver: random stalls, ready stretches, and one long hold-off
  initial begin : receiver
    int  r;
    int  dur;
    bit  lvl;
    bit  held_off;
    out_ready_i = 1'b0;
    held_off    = 1'b0;
    @(posedge clk_i);
    forever begin
      if (!held_off && results_seen >= 60) begin
        held_off = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          lvl = 1'b1;
          dur = $urandom_range(1, 4);
        end else if (r < 88) begin
          lvl = 1'b0;
          dur = $urandom_range(1, 3);
        end else if (r < 97) begin
          lvl = 1'b0;
          dur = $urandom_range(5, 20);
        end else begin
          lvl = 1'b1;
          dur = $urandom_range(30, 80);
        end
        out_ready_i <= lvl;
        repeat (dur) @(posedge clk_i);
      end
    end
  end

  initial begin : stimulus
    int pop_pct;
    int fill_n;
    int drain_wait;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    opcode_i     = OP_INSERT;
    byte_value_i = 8'h00;
    pin_valid    = 1'b0;
    pin_res      = '0;
    for (int i = 0; i < NumBins; i++) bin_count[i] = '0;
    bin_used        = '0;
    held_total      = 0;
    ovf_sticky      = 1'b0;
    err_count       = 0;
    reqs_taken      = 0;
    results_seen    = 0;
    empty_pops      = 0;
    dropped_inserts = 0;
    peak_held       = 0;
    no_gap          = 1'b0;
    hot_base        = 8'h00;
    pop_pct         = 50;

    // directed: empty pops, extremes, duplicates, value ignored on pop
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 1, 8'h00, 1'b1));
    dir_rows.push_back(mk_row(OP_INSERT, 8'hFF, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 1, 8'hFF, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 1, 8'h00, 1'b1));
    dir_rows.push_back(mk_row(OP_INSERT, 8'h00, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'hFF, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'h80, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'h00, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'h01, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'hFE, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 1, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'hFF, 1, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'hAA, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_INSERT, 8'h55, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 1, 8'hFF, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 1, 8'h00, 1'b1));
    dir_rows.push_back(mk_row(OP_POP,    8'hFF, 1, 8'h00, 1'b1));
    dir_rows.push_back(mk_row(OP_INSERT, 8'h7F, 0, 8'h00, 1'b0));
    dir_rows.push_back(mk_row(OP_POP,    8'h00, 0, 8'h00, 1'b0));

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      send_request(dir_rows[k].op, dir_rows[k].value, dir_rows[k].pinned, dir_rows[k].res);
    end

    // mixed traffic; pop mix changes per segment so the store both drains and grows
    for (int i = 0; i < 300; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 20;
          1: pop_pct = 50;
          default: pop_pct = 80;
        endcase
        hot_base = 8'($urandom_range(0, 255));
      end
      no_gap = (i >= 100 && i < 140);
      send_random(pop_pct);
    end

    // fill to capacity, then a few inserts that must be dropped
    idle_cycles(1);
    fill_n = int'(Capacity - held_total) + 8;
    for (int i = 0; i < fill_n; i++) begin
      if (i % 64 == 0) hot_base = 8'($urandom_range(0, 255));
      no_gap = (i % 256) < 40;
      send_random(0);
    end

    // traffic around a full store with the overflow flag now set
    for (int i = 0; i < 320; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(0, 2))
          0: pop_pct = 40;
          1: pop_pct = 60;
          default: pop_pct = 85;
        endcase
        hot_base = 8'($urandom_range(0, 255));
      end
      no_gap = (i >= 200 && i < 240);
      send_random(pop_pct);
    end

    idle_cycles(1);
    drain_wait = 0;
    while (pending_pops.size() != 0 && drain_wait < 5000) begin
      @(posedge clk_i);
      drain_wait++;
    end
    repeat (20) @(posedge clk_i);
    if (pending_pops.size() != 0) begin
      report_mismatch("pop results never returned", pending_pops.size(), 0);
    end

    $display("Sent %0d requests (%0d inserts dropped on a full store), checked %0d pop results.",
             reqs_taken, dropped_inserts, results_seen);
    $display("%0d pops hit an empty store; peak occupancy %0d of %0d; %0d mismatches.",
             empty_pops, peak_held, Capacity, err_count);
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
